// ===== sv/assert_macros.svh =====
// assertion helpers for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked at the next clock
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpa_pkg.sv =====
package bpa_pkg;

  localparam int NumPages  = 1024;
  localparam int MaxOrder  = 10;
  localparam int PageShift = 12;
  localparam int PageW     = 10;
  localparam int OrdW      = 4;
  localparam int BytesW    = 23;
  localparam int NeedW     = BytesW - PageShift + 1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NO_SPACE = 1'b1;

  // one entry of the page table
  typedef struct packed {
    logic            used;
    logic            head;
    logic [OrdW-1:0] order;
  } entry_t;

  localparam int EntryW = 2 + OrdW;

  typedef struct packed {
    logic             wr;
    logic [PageW-1:0] waddr;
    entry_t           wdata;
    logic [PageW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_EV,
    S_MRG_RD,
    S_MRG_EV,
    S_MRG_WR,
    S_DONE
  } state_t;

endpackage

// ===== sv/buddy_page_allocator_core.sv =====
// Buddy allocator over 1024 pages of 4096 bytes, block orders 0 to 10. An
// allocate request (cmd 0) rounds request_bytes up to whole pages (zero means
// one page), scans block heads first-fit from page 0, halves an oversized free
// block until it fits, and returns start page and order, or status 1 when no
// block is large enough. A free request (cmd 1) releases a block head and merges
// it with free buddies of equal order; it always answers status 0 with zero
// fields. Every request gets exactly one response. All state lives in one page
// table memory with registered reads. An allocate is accepted, then reads and
// evaluates each head visited; each split writes both halves and then
// re-reads the same head. A free is accepted, then reads and releases the
// head, and each merge reads the buddy, evaluates it and writes the merged
// head. After reset a clearing pass over all 1024 pages rebuilds the table
// before the first request is taken. Responses sit in an output register; a
// new request is taken once the previous response has been delivered.
`include "assert_macros.svh"
module buddy_page_allocator_core (
  input  logic        clk,
  input  logic        rst,
  // request: [22:0] request_bytes, [32:23] page_number, rest zero
  input  logic [39:0] s_tdata,
  // request kind: [0] cmd
  input  logic        s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // response: [9:0] block_start, [13:10] block_order, [15:14] zero
  output logic [15:0] m_tdata,
  // response kind: [0] status
  output logic        m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready
);

  bpa_pkg::state_t state, state_next;
  logic                        cmd;
  logic [bpa_pkg::NeedW-1:0]   need;
  logic [bpa_pkg::PageW:0]     pos, pos_next;
  logic [bpa_pkg::OrdW-1:0]    ord, ord_next;   // order of the split halves or of the block being merged
  logic [bpa_pkg::PageW-1:0]   mate, mate_next;
  logic                        res_status, res_status_next;
  logic [bpa_pkg::PageW-1:0]   res_start, res_start_next;
  logic [bpa_pkg::OrdW-1:0]    res_order, res_order_next;
  bpa_pkg::mem_req_t           req;
  bpa_pkg::entry_t             rd;
  logic                        busy;
  logic                        take;
  logic [bpa_pkg::NeedW-1:0]   need_in;
  logic [bpa_pkg::BytesW:0]    bytes_up;
  logic [bpa_pkg::MaxOrder+1:0] size;  // 1 << order, wide enough for order 10
  logic [bpa_pkg::PageW-1:0]   cur;
  logic [bpa_pkg::PageW-1:0]   low;

  assign s_tready = (state == bpa_pkg::S_IDLE) && !busy;
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = (state == bpa_pkg::S_DONE);
  assign m_tdata  = {2'b0, res_order, res_start};
  assign m_tuser  = res_status;

  // round bytes up to pages, zero counts as one page
  assign bytes_up = {1'b0, s_tdata[22:0]} +
                    (bpa_pkg::BytesW+1)'((1 << bpa_pkg::PageShift) - 1);
  assign need_in  = (bytes_up[bpa_pkg::BytesW:bpa_pkg::PageShift] == '0) ?
                    bpa_pkg::NeedW'(1) : bytes_up[bpa_pkg::BytesW:bpa_pkg::PageShift];

  assign size = (bpa_pkg::MaxOrder+2)'(1) << rd.order;
  assign cur  = pos[bpa_pkg::PageW-1:0];
  assign low  = cur & mate;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd  <= s_tuser;
      need <= need_in;
    end
    pos        <= pos_next;
    ord        <= ord_next;
    mate       <= mate_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
    res_order  <= res_order_next;
  end

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    ord_next        = ord;
    mate_next       = mate;
    res_status_next = res_status;
    res_start_next  = res_start;
    res_order_next  = res_order;
    req.wr          = 1'b0;
    req.waddr       = cur;
    req.wdata       = '0;
    req.raddr       = cur;
    unique case (state)
      bpa_pkg::S_IDLE: begin
        if (take) begin
          res_status_next = bpa_pkg::ST_OK;
          res_start_next  = '0;
          res_order_next  = '0;
          if (s_tuser == bpa_pkg::CMD_FREE) begin
            pos_next   = {1'b0, s_tdata[32:23]};
            state_next = bpa_pkg::S_FREE_RD;
          end else begin
            pos_next   = '0;
            state_next = bpa_pkg::S_SCAN_RD;
          end
        end
      end
      bpa_pkg::S_SCAN_RD: begin
        req.raddr = cur;
        if (pos[bpa_pkg::PageW]) begin
          res_status_next = bpa_pkg::ST_NO_SPACE;
          state_next      = bpa_pkg::S_DONE;
        end else begin
          state_next = bpa_pkg::S_SCAN_EV;
        end
      end
      bpa_pkg::S_SCAN_EV: begin
        priority if (rd.used || (size < (bpa_pkg::MaxOrder+2)'(need))) begin
          pos_next   = pos + (bpa_pkg::PageW+1)'(size);
          state_next = bpa_pkg::S_SCAN_RD;
        end else if ((size >> 1) < (bpa_pkg::MaxOrder+2)'(need)) begin
          req.wr          = 1'b1;
          req.wdata       = rd;
          req.wdata.used  = 1'b1;
          res_start_next  = cur;
          res_order_next  = rd.order;
          state_next      = bpa_pkg::S_DONE;
        end else begin
          // lower half shrinks here, upper half becomes a head next cycle
          req.wr          = 1'b1;
          req.wdata       = rd;
          req.wdata.order = rd.order - 1'b1;
          ord_next        = rd.order - 1'b1;
          mate_next       = cur + bpa_pkg::PageW'(size >> 1);
          state_next      = bpa_pkg::S_SPLIT;
        end
      end
      bpa_pkg::S_SPLIT: begin
        req.wr          = 1'b1;
        req.waddr       = mate;
        req.wdata.used  = 1'b0;
        req.wdata.head  = 1'b1;
        req.wdata.order = ord;
        state_next      = bpa_pkg::S_SCAN_RD;
      end
      bpa_pkg::S_FREE_RD: begin
        req.raddr  = cur;
        state_next = bpa_pkg::S_FREE_EV;
      end
      bpa_pkg::S_FREE_EV: begin
        if (rd.head) begin
          req.wr         = 1'b1;
          req.wdata      = rd;
          req.wdata.used = 1'b0;
          ord_next       = rd.order;
          mate_next      = cur ^ bpa_pkg::PageW'(size);
          if (rd.order >= bpa_pkg::OrdW'(bpa_pkg::MaxOrder)) begin
            state_next = bpa_pkg::S_DONE;
          end else begin
            state_next = bpa_pkg::S_MRG_RD;
          end
        end else begin
          state_next = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_MRG_RD: begin
        req.raddr  = mate;
        state_next = bpa_pkg::S_MRG_EV;
      end
      bpa_pkg::S_MRG_EV: begin
        if (rd.head && !rd.used && (rd.order == ord)) begin
          // clear the upper head, the lower one is written next cycle
          req.wr     = 1'b1;
          req.waddr  = cur | mate;
          req.wdata  = '0;
          state_next = bpa_pkg::S_MRG_WR;
        end else begin
          state_next = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_MRG_WR: begin
        req.wr          = 1'b1;
        req.waddr       = low;
        req.wdata.used  = 1'b0;
        req.wdata.head  = 1'b1;
        req.wdata.order = ord + 1'b1;
        ord_next        = ord + 1'b1;
        pos_next        = {1'b0, low};
        mate_next       = low ^ bpa_pkg::PageW'((bpa_pkg::MaxOrder+2)'(1) << (ord + 1'b1));
        if (ord + 1'b1 >= bpa_pkg::OrdW'(bpa_pkg::MaxOrder)) begin
          state_next = bpa_pkg::S_DONE;
        end else begin
          state_next = bpa_pkg::S_MRG_RD;
        end
      end
      bpa_pkg::S_DONE: begin
        if (m_tready) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      default: state_next = bpa_pkg::S_IDLE;
    endcase
  end

  bpa_table u_table (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rdata(rd),
    .busy (busy)
  );

  `ASSERT_IMPL(a_no_take_busy, clk, rst, busy, !s_tready, "request taken during clear")
  `ASSERT_IMPL(a_free_ok, clk, rst, m_tvalid && (cmd == bpa_pkg::CMD_FREE),
               (m_tdata == '0) && (m_tuser == bpa_pkg::ST_OK), "free answered nonzero")
  `ASSERT_IMPL(a_fail_zero, clk, rst, m_tvalid && (m_tuser == bpa_pkg::ST_NO_SPACE),
               m_tdata[13:0] == '0, "failed allocate has fields")
  `ASSERT_NEXT(a_resp_hold, clk, rst, m_tvalid && !m_tready,
               m_tvalid && $stable(m_tdata) && $stable(m_tuser), "response dropped")
  `ASSERT_IMPL(a_order_range, clk, rst, m_tvalid,
               m_tdata[13:10] <= 4'(bpa_pkg::MaxOrder), "order out of range")

endmodule

// ===== sv/bpa_ram.sv =====
// page table memory, one write and one registered read per cycle
module bpa_ram #(
  parameter int Depth = 1024,
  parameter int Width = 6
) (
  input  logic                     clk,
  input  logic                     wr,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bpa_table.sv =====
// page table with reset clearing pass; page 0 starts as a free head of order 10, all other pages as non-heads
module bpa_table (
  input  logic                    clk,
  input  logic                    rst,
  input  bpa_pkg::mem_req_t       req,
  output bpa_pkg::entry_t         rdata,
  output logic                    busy
);

  logic [bpa_pkg::PageW:0]    clr;
  logic                       wr;
  logic [bpa_pkg::PageW-1:0]  waddr;
  bpa_pkg::entry_t            wdata;
  logic [bpa_pkg::EntryW-1:0] raw;

  assign busy = !clr[bpa_pkg::PageW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (busy) begin
      clr <= clr + 1'b1;
    end
  end

  always_comb begin
    if (busy) begin
      wr          = 1'b1;
      waddr       = clr[bpa_pkg::PageW-1:0];
      wdata.used  = 1'b0;
      wdata.head  = (clr[bpa_pkg::PageW-1:0] == '0);
      wdata.order = (clr[bpa_pkg::PageW-1:0] == '0) ?
                    bpa_pkg::OrdW'(bpa_pkg::MaxOrder) : '0;
    end else begin
      wr    = req.wr;
      waddr = req.waddr;
      wdata = req.wdata;
    end
  end

  bpa_ram #(.Depth(bpa_pkg::NumPages), .Width(bpa_pkg::EntryW)) u_ram (
    .clk  (clk),
    .wr   (wr),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(req.raddr),
    .rdata(raw)
  );

  assign rdata = bpa_pkg::entry_t'(raw);

endmodule

// ===== verif/buddy_page_allocator_core_test.sv =====
`timescale 1ns / 100ps
module buddy_page_allocator_core_test;

  logic        clk = 1'b0;
  logic        rst;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tvalid;
  logic        m_tready;

  buddy_page_allocator_core DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready)
  );

  typedef struct packed {
    logic                      status;
    logic [bpa_pkg::PageW-1:0] start;
    logic [bpa_pkg::OrdW-1:0]  order;
  } grant_t;

  // shadow page table
  logic                     used_tab [bpa_pkg::NumPages];
  logic                     head_tab [bpa_pkg::NumPages];
  logic [bpa_pkg::OrdW-1:0] ord_tab  [bpa_pkg::NumPages];

  grant_t grants_due[$];
  int     error_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_off;
  int     hold_cycles;
  // start pages of blocks currently granted, used to aim free requests
  int     live_blocks[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic shadow_reset();
    for (int i = 0; i < bpa_pkg::NumPages; i++) begin
      used_tab[i] = 1'b0;
      head_tab[i] = (i == 0);
      ord_tab[i]  = (i == 0) ? bpa_pkg::OrdW'(bpa_pkg::MaxOrder) : '0;
    end
  endtask

  // merge a released block with free buddies of equal order
  function automatic void coalesce_from(input int pos);
    int ord;
    int mate;
    int lo;
    int hi;
    while (pos < bpa_pkg::NumPages) begin
      ord = int'(ord_tab[pos]);
      if (ord >= bpa_pkg::MaxOrder) return;
      mate = pos ^ (1 << ord);
      if (mate >= bpa_pkg::NumPages || !head_tab[mate] || used_tab[mate] ||
          int'(ord_tab[mate]) != ord)
        return;
      lo = (pos < mate) ? pos : mate;
      hi = (pos < mate) ? mate : pos;
      ord_tab[lo]  = bpa_pkg::OrdW'(ord + 1);
      used_tab[lo] = 1'b0;
      head_tab[lo] = 1'b1;
      ord_tab[hi]  = '0;
      used_tab[hi] = 1'b0;
      head_tab[hi] = 1'b0;
      pos = lo;
    end
  endfunction

  function automatic grant_t predict_grant(input logic cmd, input logic [22:0] bytes,
                                           input logic [9:0] page);
    grant_t g;
    longint need;
    longint size;
    int pos;
    int ord;
    int mate;
    g = '0;
    if (cmd == bpa_pkg::CMD_FREE) begin
      if (head_tab[page]) begin
        used_tab[page] = 1'b0;
        coalesce_from(int'(page));
      end
      return g;
    end
    need = (longint'(bytes) + (1 << bpa_pkg::PageShift) - 1) >> bpa_pkg::PageShift;
    if (need == 0) need = 1;
    pos = 0;
    while (pos < bpa_pkg::NumPages) begin
      ord  = int'(ord_tab[pos]);
      size = longint'(1) << ord;
      if (used_tab[pos] || size < need) begin
        pos += int'(size);
      end else if (size / 2 < need) begin
        used_tab[pos] = 1'b1;
        g.status = bpa_pkg::ST_OK;
        g.start  = bpa_pkg::PageW'(pos);
        g.order  = bpa_pkg::OrdW'(ord);
        return g;
      end else begin
        // split, upper half becomes a free head
        mate = pos + int'(size / 2);
        ord_tab[pos] = bpa_pkg::OrdW'(ord - 1);
        if (mate < bpa_pkg::NumPages) begin
          head_tab[mate] = 1'b1;
          used_tab[mate] = 1'b0;
          ord_tab[mate]  = bpa_pkg::OrdW'(ord - 1);
        end
      end
    end
    g.status = bpa_pkg::ST_NO_SPACE;
    return g;
  endfunction

  // send one request and record its expected response
  task automatic send_request(input logic cmd, input logic [22:0] bytes,
                              input logic [9:0] page);
    grant_t g;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tdata  <= {7'b0, page, bytes};
    s_tuser  <= cmd;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = predict_grant(cmd, bytes, page);
    grants_due.push_back(g);
    if (cmd == bpa_pkg::CMD_ALLOC && g.status == bpa_pkg::ST_OK)
      live_blocks.push_back(int'(g.start));
  endtask

  task automatic alloc_req(input logic [22:0] bytes);
    send_request(bpa_pkg::CMD_ALLOC, bytes, 10'($urandom_range(1023)));
  endtask

  task automatic free_req(input logic [9:0] page);
    send_request(bpa_pkg::CMD_FREE, 23'($urandom_range(23'h7fffff)), page);
  endtask

  task automatic free_random_live();
    int k;
    k = $urandom_range(live_blocks.size() - 1);
    free_req(10'(live_blocks[k]));
    live_blocks.delete(k);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // receive side: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_cycles++;
        if (hold_cycles >= 600) begin
          hold_off = 1'b0;
          hold_cycles = 0;
        end
      end
    end
  end

  // response checker
  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.start  = m_tdata[9:0];
      got.order  = m_tdata[13:10];
      if (grants_due.size() == 0) begin
        report_mismatch("unexpected response", int'(m_tdata), 0);
      end else begin
        want = grants_due.pop_front();
        if (got.status != want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.start != want.start)
          report_mismatch("block_start", int'(got.start), int'(want.start));
        if (got.order != want.order)
          report_mismatch("block_order", int'(got.order), int'(want.order));
      end
    end
  end

  task automatic test_directed();
    alloc_req(23'd0);          // zero bytes is one page
    alloc_req(23'd1);
    alloc_req(23'd4096);
    alloc_req(23'd4097);       // rounds to two pages
    alloc_req(23'd4194304);    // whole memory, no space now
    alloc_req(23'h7fffff);     // request too large
    free_req(10'd1);
    free_req(10'd1);           // free of a block already free
    free_req(10'd3);           // already a free head, its buddy is in use
    free_req(10'd1023);
    free_req(10'd0);
    free_req(10'd2);
    free_req(10'd4);
    alloc_req(23'd4194304);    // merges back to order ten
    free_req(10'd0);
    alloc_req(23'd2097152);
    alloc_req(23'd2097153);
    alloc_req(23'd2097152);
    free_req(10'd512);
    free_req(10'd0);
    live_blocks.delete();
    wait_drained();
  endtask

  task automatic test_random(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45 || live_blocks.size() == 0) begin
        case ($urandom_range(3))
          0: alloc_req(23'($urandom_range(4096)));
          1: alloc_req(23'($urandom_range(65536)));
          2: alloc_req(23'($urandom_range(23'h7fffff)));
          default: alloc_req(23'($urandom_range(4194304)));
        endcase
      end else if (r < 92) begin
        free_random_live();
      end else begin
        free_req(10'($urandom_range(1023)));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    test_random(40);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tvalid = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    shadow_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300);
    send_idle_pct = 47;
    test_random(300);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 47;
    test_random(300);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    test_random(300);
    wait_drained();
    test_backpressure();
    wait_drained();
    if (error_count == 0) begin
      $display("buddy_page_allocator_core_test: clean");
    end else begin
      $display("buddy_page_allocator_core_test: errors");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("buddy_page_allocator_core_test: errors");
    $finish;
  end

endmodule

// ===== buddy_page_allocator_core.f =====
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_table.sv
sv/buddy_page_allocator_core.sv
verif/buddy_page_allocator_core_test.sv
